FILE: rtl/qisd_pkg.sv
package qisd_pkg;

    // color table
    localparam int IDX_ENTRIES = 64;
    localparam int IDX_BITS    = 6;

    // command queue between parser and emitter
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;

    // file framing
    localparam logic [31:0] MAGIC          = 32'h716f6966;
    localparam logic [3:0]  HDR_MAGIC_END  = 4'd4;
    localparam logic [3:0]  HDR_WIDTH_END  = 4'd8;
    localparam logic [3:0]  HDR_HEIGHT_END = 4'd12;
    localparam logic [3:0]  HDR_LAST       = 4'd13;
    localparam logic [3:0]  END_ZEROS      = 4'd7;
    localparam logic [7:0]  END_LAST_BYTE  = 8'h01;

    // chunk tags
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;
    localparam logic [7:0] CODE_RGB  = 8'hfe;
    localparam logic [7:0] CODE_RGBA = 8'hff;

    // pixel packing is r g b a from msb down
    localparam logic [31:0] RESET_PIXEL = 32'h0000_00ff;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_RGB  = 2'd1,
        OP_RGBA = 2'd2,
        OP_LUMA = 2'd3
    } t_op;

    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_PIXELS  = 8'b0000_0010,
        PH_OPERAND = 8'b0000_0100,
        PH_END     = 8'b0000_1000,
        PH_DONE    = 8'b0001_0000,
        PH_ERROR   = 8'b0010_0000,
        PH_FETCH   = 8'b0100_0000,
        PH_LOAD    = 8'b1000_0000
    } t_phase;

    // one queued command, count is repeats minus one
    typedef struct packed {
        t_kind       kind;
        logic [31:0] pixel;
        logic [31:0] width;
        logic [31:0] height;
        logic [5:0]  count;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: rtl/qisd_front.sv
module qisd_front import qisd_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_image,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    function automatic logic [IDX_BITS-1:0] f_hash(input logic [31:0] p);
        logic [IDX_BITS-1:0] hr, hg, hb, ha;
        begin
            hr = p[24 +: IDX_BITS];
            hg = p[16 +: IDX_BITS];
            hb = p[8 +: IDX_BITS];
            ha = p[0 +: IDX_BITS];
            return hr * IDX_BITS'(3) + hg * IDX_BITS'(5) + hb * IDX_BITS'(7)
                 + ha * IDX_BITS'(11);
        end
    endfunction

    t_phase                r_phase, n_phase;
    logic [3:0]            r_cnt, n_cnt;
    logic [31:0]           r_w, n_w;
    logic [31:0]           r_h, n_h;
    logic [COUNT_BITS-1:0] r_left, n_left;
    t_op                   r_op, n_op;
    logic [7:0]            r_dg, n_dg;
    logic [31:0]           r_cur, n_cur;
    logic [63:0]           r_total, n_total;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic                  r_store, n_store;
    logic [IDX_ENTRIES-1:0] r_valid;
    logic [31:0]           r_mem [IDX_ENTRIES];
    logic [31:0]           r_rd;
    logic                  r_rd_valid;

    logic        accept, sos;
    t_phase      eff_phase;
    logic [3:0]  eff_cnt;
    logic [31:0] eff_w, eff_h;
    logic [7:0]  b;
    logic        put;
    logic [6:0]  put_count, run_n;
    logic [31:0] new_pix;
    logic [63:0] prod;
    logic [3:0]  need;
    logic [7:0]  cr, cg, cb;

    assign o_ready = !i_qstat.full && (r_phase != PH_FETCH) && (r_phase != PH_LOAD);
    assign accept  = i_valid && o_ready;
    assign sos     = accept && i_start_of_image;
    assign b       = i_data_byte;
    assign prod    = 64'(r_w) * 64'(r_h);
    assign cr      = r_cur[31:24];
    assign cg      = r_cur[23:16];
    assign cb      = r_cur[15:8];

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_w       = r_w;
        n_h       = r_h;
        n_left    = r_left;
        n_op      = r_op;
        n_dg      = r_dg;
        n_cur     = r_cur;
        n_total   = r_total;
        n_idx     = r_idx;
        n_store   = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;
        put       = 1'b0;
        put_count = 7'd1;
        new_pix   = r_cur;
        run_n     = 7'd1;
        need      = (r_op == OP_RGBA) ? 4'd4 : 4'd3;

        eff_phase = sos ? PH_HEADER : r_phase;
        eff_cnt   = sos ? 4'd0 : r_cnt;
        eff_w     = sos ? 32'd0 : r_w;
        eff_h     = sos ? 32'd0 : r_h;

        if (sos) begin
            n_phase = PH_HEADER;
            n_cnt   = 4'd0;
            n_w     = 32'd0;
            n_h     = 32'd0;
            n_left  = '0;
            n_op    = OP_NONE;
            n_dg    = 8'd0;
            n_cur   = RESET_PIXEL;
        end

        if (accept) begin
            case (eff_phase)
                PH_HEADER: begin
                    if (eff_cnt < HDR_MAGIC_END && b != MAGIC[(3 - eff_cnt[1:0]) * 8 +: 8]) begin
                        o_push       = 1'b1;
                        o_cmd.kind   = KIND_ERROR;
                        o_cmd.width  = eff_w;
                        o_cmd.height = eff_h;
                        n_phase      = PH_ERROR;
                    end else begin
                        if (eff_cnt >= HDR_MAGIC_END && eff_cnt < HDR_WIDTH_END) begin
                            n_w = {eff_w[23:0], b};
                        end else if (eff_cnt >= HDR_WIDTH_END && eff_cnt < HDR_HEIGHT_END) begin
                            n_h = {eff_h[23:0], b};
                        end
                        // product is ready one byte ahead of the check
                        if (eff_cnt == HDR_HEIGHT_END) begin
                            n_total = prod;
                        end
                        if (eff_cnt < HDR_LAST) begin
                            n_cnt = eff_cnt + 4'd1;
                        end else begin
                            n_cnt        = 4'd0;
                            o_push       = 1'b1;
                            o_cmd.width  = r_w;
                            o_cmd.height = r_h;
                            if (r_total[63:COUNT_BITS] != '0) begin
                                o_cmd.kind = KIND_ERROR;
                                n_phase    = PH_ERROR;
                            end else begin
                                o_cmd.kind = KIND_HEADER;
                                n_left     = r_total[COUNT_BITS-1:0];
                                n_phase    = (r_total[COUNT_BITS-1:0] == '0) ? PH_END
                                                                              : PH_PIXELS;
                            end
                        end
                    end
                end
                PH_PIXELS: begin
                    case (b[7:6])
                        TAG_RUN: begin
                            if (b == CODE_RGB) begin
                                n_op    = OP_RGB;
                                n_cnt   = 4'd0;
                                n_phase = PH_OPERAND;
                            end else if (b == CODE_RGBA) begin
                                n_op    = OP_RGBA;
                                n_cnt   = 4'd0;
                                n_phase = PH_OPERAND;
                            end else begin
                                put       = 1'b1;
                                put_count = {1'b0, b[5:0]} + 7'd1;
                            end
                        end
                        TAG_INDEX: begin
                            n_idx   = b[5:0];
                            n_phase = PH_FETCH;
                        end
                        TAG_DIFF: begin
                            new_pix[31:24] = cr + {6'd0, b[5:4]} - 8'd2;
                            new_pix[23:16] = cg + {6'd0, b[3:2]} - 8'd2;
                            new_pix[15:8]  = cb + {6'd0, b[1:0]} - 8'd2;
                            put            = 1'b1;
                        end
                        default: begin
                            n_dg    = {2'd0, b[5:0]} - 8'd32;
                            n_op    = OP_LUMA;
                            n_cnt   = 4'd0;
                            n_phase = PH_OPERAND;
                        end
                    endcase
                end
                PH_OPERAND: begin
                    if (r_op == OP_LUMA) begin
                        new_pix[23:16] = cg + r_dg;
                        new_pix[31:24] = cr + {4'd0, b[7:4]} - 8'd8 + r_dg;
                        new_pix[15:8]  = cb + {4'd0, b[3:0]} - 8'd8 + r_dg;
                        put            = 1'b1;
                    end else begin
                        case (r_cnt[1:0])
                            2'd0:    new_pix[31:24] = b;
                            2'd1:    new_pix[23:16] = b;
                            2'd2:    new_pix[15:8]  = b;
                            default: new_pix[7:0]   = b;
                        endcase
                        n_cur = new_pix;
                        n_cnt = r_cnt + 4'd1;
                        if (r_cnt + 4'd1 >= need) begin
                            put = 1'b1;
                        end
                    end
                end
                PH_END: begin
                    if (eff_cnt < END_ZEROS) begin
                        if (b != 8'd0) begin
                            o_push       = 1'b1;
                            o_cmd.kind   = KIND_ERROR;
                            o_cmd.width  = r_w;
                            o_cmd.height = r_h;
                            n_phase      = PH_ERROR;
                        end else begin
                            n_cnt = eff_cnt + 4'd1;
                        end
                    end else if (b != END_LAST_BYTE) begin
                        o_push       = 1'b1;
                        o_cmd.kind   = KIND_ERROR;
                        o_cmd.width  = r_w;
                        o_cmd.height = r_h;
                        n_phase      = PH_ERROR;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_END;
                        n_cnt      = 4'd0;
                        n_phase    = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_phase == PH_FETCH) begin
            n_phase = PH_LOAD;
        end else if (r_phase == PH_LOAD) begin
            // never-written table entries read as zero
            new_pix = r_rd_valid ? r_rd : 32'd0;
            put     = 1'b1;
        end

        // emit, truncate the run at image end, remember for the table
        if (put) begin
            if (r_left < COUNT_BITS'(put_count)) begin
                run_n = r_left[6:0];
            end else begin
                run_n = put_count;
            end
            n_cur       = new_pix;
            n_left      = r_left - COUNT_BITS'(run_n);
            n_phase     = (r_left == COUNT_BITS'(run_n)) ? PH_END : PH_PIXELS;
            n_cnt       = 4'd0;
            n_op        = OP_NONE;
            n_store     = 1'b1;
            o_push      = 1'b1;
            o_cmd.kind  = KIND_PIXEL;
            o_cmd.pixel = new_pix;
            o_cmd.count = 6'(run_n - 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= 4'd0;
            r_w     <= 32'd0;
            r_h     <= 32'd0;
            r_left  <= '0;
            r_op    <= OP_NONE;
            r_dg    <= 8'd0;
            r_cur   <= RESET_PIXEL;
            r_store <= 1'b0;
            r_valid <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_w     <= n_w;
            r_h     <= n_h;
            r_left  <= n_left;
            r_op    <= n_op;
            r_dg    <= n_dg;
            r_cur   <= n_cur;
            r_store <= n_store;
            if (sos) begin
                r_valid <= '0;
            end else if (r_store) begin
                r_valid[f_hash(r_cur)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_idx   <= n_idx;
    end

    // table write comes from the registered pixel and store flag, read is registered
    always_ff @(posedge i_clk) begin
        if (r_store && !sos) begin
            r_mem[f_hash(r_cur)] <= r_cur;
        end
        if (r_phase == PH_FETCH) begin
            r_rd       <= r_mem[r_idx];
            r_rd_valid <= r_valid[r_idx];
        end
    end

endmodule

FILE: rtl/qisd_fifo.sv
module qisd_fifo import qisd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_qstat
);

    t_cmd                r_slot [QDEPTH];
    logic [QPTR_BITS-1:0] r_wp, r_rp;
    logic [QPTR_BITS:0]   r_fill;

    assign o_cmd         = r_slot[r_rp];
    assign o_qstat.full  = (r_fill == (QPTR_BITS + 1)'(QDEPTH));
    assign o_qstat.empty = (r_fill == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (QPTR_BITS + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (QPTR_BITS + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: rtl/qisd_back.sv
module qisd_back import qisd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_q_cmd,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic        o_last_of_run
);

    logic       r_busy;
    t_cmd       r_cmd;
    logic [5:0] r_rem;
    logic       done_beat;

    assign done_beat = r_busy && i_ready && (r_rem == 6'd0);
    assign o_pop     = !i_qstat.empty && (!r_busy || done_beat);

    assign o_valid        = r_busy;
    assign o_result_kind  = r_cmd.kind;
    assign o_red          = r_cmd.pixel[31:24];
    assign o_green        = r_cmd.pixel[23:16];
    assign o_blue         = r_cmd.pixel[15:8];
    assign o_alpha        = r_cmd.pixel[7:0];
    assign o_image_width  = r_cmd.width;
    assign o_image_height = r_cmd.height;
    assign o_last_of_run  = (r_rem == 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem  <= 6'd0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_rem  <= i_q_cmd.count;
            end else if (done_beat) begin
                r_busy <= 1'b0;
            end else if (r_busy && i_ready) begin
                r_rem <= r_rem - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

endmodule

FILE: rtl/qoi_image_stream_decoder.sv
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_data_byte, i_start_of_image
// result    out        o_valid / i_ready  o_result_kind, o_red .. o_alpha,
//                                         o_image_width, o_image_height, o_last_of_run
//
// one file byte a cycle while o_ready is high; an index chunk reads the color table, then loads
// a run gives a pixel beat a cycle while i_ready is high, 1 to 62 beats, from the emitter alone
// the parser runs ahead through a 4-entry command queue and holds o_ready low when it is full
// synchronous active-low reset; start_of_image clears the color table at once via valid bits
module qoi_image_stream_decoder import qisd_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_image,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic        o_last_of_run
);

    // parser to queue
    logic   push;
    t_cmd   push_cmd;
    // queue to emitter
    logic   pop;
    t_cmd   head_cmd;
    t_qstat qstat;

    // header, chunk decode, current pixel and color table
    qisd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_start_of_image (i_start_of_image),
        .i_qstat          (qstat),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // decouples byte intake from run expansion
    qisd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    // output register, repeats a pixel for runs
    qisd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_cmd        (head_cmd),
        .i_qstat        (qstat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import qisd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS = 32;

    // one result beat, fields in port order
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [31:0] w;
        logic [31:0] h;
        logic        last;
    } t_beat;

    // directed stimulus row, typed expectation only where it is obvious
    typedef struct {
        logic [7:0]  data;
        logic        sof;
        logic        typed;
        t_kind       kind;
        logic [31:0] w;
        logic [31:0] h;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_start_of_image;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [31:0] o_image_width;
    logic [31:0] o_image_height;
    logic        o_last_of_run;

    // no idling on either side while this is high
    logic        calm;

    int          fails = 0;
    int          live_items = 0;

    // decoder state as the predictor sees it
    t_phase      dec_phase;
    logic [3:0]  dec_cnt;
    logic [31:0] dec_w;
    logic [31:0] dec_h;
    logic [31:0] dec_left;
    t_op         dec_op;
    logic [7:0]  dec_dg;
    logic [31:0] dec_px;
    logic [31:0] dec_tab [IDX_ENTRIES];

    // beats from the byte just taken, and all beats still to come out
    t_beat       step_beats [$];
    t_beat       decoded_q [$];

    // typed expectation that overrides the prediction for one directed row
    logic        row_typed = 1'b0;
    t_beat       row_beat;
    t_row        dir_rows [$];

    qoi_image_stream_decoder #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_start_of_image(i_start_of_image),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_kind   (o_result_kind),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_image_width   (o_image_width),
        .o_image_height  (o_image_height),
        .o_last_of_run   (o_last_of_run)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop in case the decoder hangs
    initial begin
        #10ms;
        $display("qoi_image_stream_decoder test failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [5:0] color_hash(input logic [31:0] p);
        int s;
        s = 3 * int'(p[31:24]) + 5 * int'(p[23:16]) + 7 * int'(p[15:8]) + 11 * int'(p[7:0]);
        return s[5:0];
    endfunction

    task automatic dec_clear();
        dec_phase = PH_HEADER;
        dec_cnt   = '0;
        dec_w     = '0;
        dec_h     = '0;
        dec_left  = '0;
        dec_op    = OP_NONE;
        dec_dg    = '0;
        dec_px    = RESET_PIXEL;
        foreach (dec_tab[i]) dec_tab[i] = '0;
    endtask

    task automatic put_beat(input t_kind kind, input logic [31:0] px, input logic [31:0] w,
                            input logic [31:0] h, input logic last);
        t_beat bt;
        bt.kind = kind;
        bt.r    = px[31:24];
        bt.g    = px[23:16];
        bt.b    = px[15:8];
        bt.a    = px[7:0];
        bt.w    = w;
        bt.h    = h;
        bt.last = last;
        step_beats.push_back(bt);
    endtask

    task automatic fail_beat();
        put_beat(KIND_ERROR, '0, dec_w, dec_h, 1'b1);
        dec_phase = PH_ERROR;
    endtask

    // repeat the current pixel, cut at the image end, and remember it in the table
    task automatic emit_pixels(input logic [31:0] count);
        logic [31:0] n;
        n = (count > dec_left) ? dec_left : count;
        for (int unsigned i = 0; i < n; i++)
            put_beat(KIND_PIXEL, dec_px, '0, '0, (i + 1 == n));
        dec_tab[color_hash(dec_px)] = dec_px;
        dec_left  = dec_left - n;
        dec_phase = (dec_left == 0) ? PH_END : PH_PIXELS;
        dec_cnt   = '0;
        dec_op    = OP_NONE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [63:0] total;
        if (sof) dec_clear();
        case (dec_phase)
            PH_HEADER: begin
                if (dec_cnt < HDR_MAGIC_END) begin
                    if (b != MAGIC[8 * (3 - int'(dec_cnt)) +: 8]) begin
                        fail_beat();
                        return;
                    end
                end else if (dec_cnt < HDR_WIDTH_END) begin
                    dec_w = {dec_w[23:0], b};
                end else if (dec_cnt < HDR_HEIGHT_END) begin
                    dec_h = {dec_h[23:0], b};
                end
                if (dec_cnt < HDR_LAST) begin
                    dec_cnt = dec_cnt + 4'd1;
                    return;
                end
                total   = {32'd0, dec_w} * {32'd0, dec_h};
                dec_cnt = '0;
                if (total > ((64'd1 << COUNT_BITS) - 64'd1)) begin
                    fail_beat();
                    return;
                end
                dec_left  = total[31:0];
                dec_phase = (dec_left == 0) ? PH_END : PH_PIXELS;
                put_beat(KIND_HEADER, '0, dec_w, dec_h, 1'b1);
            end
            PH_PIXELS: begin
                case (b[7:6])
                    TAG_RUN: begin
                        if (b == CODE_RGB || b == CODE_RGBA) begin
                            dec_op    = (b == CODE_RGB) ? OP_RGB : OP_RGBA;
                            dec_cnt   = '0;
                            dec_phase = PH_OPERAND;
                        end else begin
                            emit_pixels({26'd0, b[5:0]} + 32'd1);
                        end
                    end
                    TAG_INDEX: begin
                        dec_px = dec_tab[b[5:0]];
                        emit_pixels(32'd1);
                    end
                    TAG_DIFF: begin
                        dec_px[31:24] = dec_px[31:24] + {6'd0, b[5:4]} - 8'd2;
                        dec_px[23:16] = dec_px[23:16] + {6'd0, b[3:2]} - 8'd2;
                        dec_px[15:8]  = dec_px[15:8] + {6'd0, b[1:0]} - 8'd2;
                        emit_pixels(32'd1);
                    end
                    default: begin
                        dec_dg    = {2'd0, b[5:0]} - 8'd32;
                        dec_op    = OP_LUMA;
                        dec_cnt   = '0;
                        dec_phase = PH_OPERAND;
                    end
                endcase
            end
            PH_OPERAND: begin
                if (dec_op == OP_LUMA) begin
                    dec_px[23:16] = dec_px[23:16] + dec_dg;
                    dec_px[31:24] = dec_px[31:24] + {4'd0, b[7:4]} - 8'd8 + dec_dg;
                    dec_px[15:8]  = dec_px[15:8] + {4'd0, b[3:0]} - 8'd8 + dec_dg;
                    emit_pixels(32'd1);
                end else begin
                    dec_px[8 * (3 - int'(dec_cnt[1:0])) +: 8] = b;
                    dec_cnt = dec_cnt + 4'd1;
                    if (dec_cnt >= ((dec_op == OP_RGBA) ? 4'd4 : 4'd3)) emit_pixels(32'd1);
                end
            end
            PH_END: begin
                if (dec_cnt < END_ZEROS) begin
                    if (b != 8'h00) fail_beat();
                    else dec_cnt = dec_cnt + 4'd1;
                end else if (b != END_LAST_BYTE) begin
                    fail_beat();
                end else begin
                    dec_phase = PH_DONE;
                    dec_cnt   = '0;
                    put_beat(KIND_END, '0, '0, '0, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- input side

    // one file byte: random gap, hold until taken, then predict its beats
    task automatic send_byte(input logic [7:0] b, input logic sof);
        while (!calm && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_start_of_image <= sof;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // bytes after an end or an error are just dropped, they do not count
        if (sof || (dec_phase != PH_DONE && dec_phase != PH_ERROR)) live_items++;
        step_beats.delete();
        decode_byte(b, sof);
        if (row_typed) begin
            step_beats.delete();
            step_beats.push_back(row_beat);
        end
        foreach (step_beats[i]) decoded_q.push_back(step_beats[i]);
    endtask

    // sender holds off until every predicted beat has come out
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [7:0] data, input logic sof, input logic typed,
                           input t_kind kind, input logic [31:0] w, input logic [31:0] h);
        t_row rw;
        rw.data  = data;
        rw.sof   = sof;
        rw.typed = typed;
        rw.kind  = kind;
        rw.w     = w;
        rw.h     = h;
        dir_rows.push_back(rw);
    endtask

    // ---------------------------------------------------------------- output side

    // receiver stalls about a quarter of the time, never while calm
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 25);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // every taken result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                $error("result beat with no prediction waiting");
                fails++;
            end else begin
                want = decoded_q.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                check_field("red", 32'(want.r), 32'(o_red));
                check_field("green", 32'(want.g), 32'(o_green));
                check_field("blue", 32'(want.b), 32'(o_blue));
                check_field("alpha", 32'(want.a), 32'(o_alpha));
                check_field("image_width", want.w, o_image_width);
                check_field("image_height", want.h, o_image_height);
                check_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        int          mode;
        int          sel;
        int          bad_pos;
        logic [7:0]  x;
        logic [7:0]  flip;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] run;
        logic [31:0] cut;
        logic [31:0] gen_px;

        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'h00;
        i_start_of_image <= 1'b0;
        i_ready          <= 1'b0;
        calm             <= 1'b0;
        dec_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bad magic on the very first byte, then a stray byte that is dropped
        add_row(8'h00, 1'b1, 1'b1, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h71, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        // 1 x 2 image header, channels byte at its maximum
        for (int k = 0; k < 4; k++)
            add_row(MAGIC[8 * (3 - k) +: 8], (k == 0), 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h01, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h02, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'hff, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(8'h00, 1'b0, 1'b1, KIND_HEADER, 32'd1, 32'd2);
        // longest run, cut to the two pixels of the image
        add_row({TAG_RUN, 6'd61}, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        // good end marker
        for (int k = 0; k < 7; k++)
            add_row(8'h00, 1'b0, 1'b0, KIND_ERROR, 32'd0, 32'd0);
        add_row(END_LAST_BYTE, 1'b0, 1'b1, KIND_END, 32'd0, 32'd0);

        foreach (dir_rows[i]) begin
            row_typed     = dir_rows[i].typed;
            row_beat      = '0;
            row_beat.kind = dir_rows[i].kind;
            row_beat.w    = dir_rows[i].w;
            row_beat.h    = dir_rows[i].h;
            row_beat.last = 1'b1;
            send_byte(dir_rows[i].data, dir_rows[i].sof);
        end
        row_typed = 1'b0;
        wait_for_results();

        // random files: mostly well formed, some broken or cut short
        live_items = 0;
        while (live_items < 320) begin
            calm <= (live_items >= 120 && live_items < 200);
            if ($urandom_range(99) < 20) wait_for_results();
            mode = $urandom_range(99);

            // magic, one byte wrong in the bad-magic files
            bad_pos = (mode >= 86 && mode < 93) ? $urandom_range(3) : 4;
            for (int k = 0; k < 4; k++) begin
                x = MAGIC[8 * (3 - k) +: 8];
                if (k == bad_pos) begin
                    flip = rand_byte();
                    if (flip == 8'h00) flip = 8'h80;
                    x = x ^ flip;
                end
                if (k <= bad_pos) send_byte(x, (k == 0));
            end
            if (bad_pos < 4) begin
                repeat ($urandom_range(3)) send_byte(rand_byte(), 1'b0);
                continue;
            end

            // dimensions: empty, oversized, or a small image
            if (mode >= 70 && mode < 78) begin
                w = $urandom;
                h = '0;
                if ($urandom_range(1) == 1) begin
                    h = w;
                    w = '0;
                end
            end else if (mode >= 78 && mode < 86) begin
                w = $urandom | 32'h0001_0000;
                h = $urandom | 32'h0001_0000;
                if ($urandom_range(3) == 0) begin
                    w = '1;
                    h = '1;
                end
            end else begin
                w = $urandom_range(8, 1);
                h = $urandom_range(8, 1);
            end
            for (int k = 3; k >= 0; k--) send_byte(w[8 * k +: 8], 1'b0);
            for (int k = 3; k >= 0; k--) send_byte(h[8 * k +: 8], 1'b0);
            // channels and colorspace, skipped by the decoder
            send_byte(rand_byte(), 1'b0);
            send_byte(rand_byte(), 1'b0);
            if (mode >= 78 && mode < 86) begin
                repeat ($urandom_range(3)) send_byte(rand_byte(), 1'b0);
                continue;
            end

            // chunks until the image is full, or cut short for a truncated file
            if (mode >= 70 && mode < 78) cut = '0;
            else if (mode >= 93) cut = $urandom_range(w * h - 1);
            else cut = w * h;
            gen_px = '0;
            while (gen_px < cut) begin
                sel = $urandom_range(99);
                x   = rand_byte();
                if (sel < 15) begin
                    send_byte(CODE_RGB, 1'b0);
                    repeat (3) send_byte(rand_byte(), 1'b0);
                    gen_px++;
                end else if (sel < 25) begin
                    send_byte(CODE_RGBA, 1'b0);
                    repeat (4) send_byte(rand_byte(), 1'b0);
                    gen_px++;
                end else if (sel < 45) begin
                    send_byte({TAG_INDEX, x[5:0]}, 1'b0);
                    gen_px++;
                end else if (sel < 62) begin
                    send_byte({TAG_DIFF, x[5:0]}, 1'b0);
                    gen_px++;
                end else if (sel < 77) begin
                    send_byte({TAG_LUMA, x[5:0]}, 1'b0);
                    send_byte(rand_byte(), 1'b0);
                    gen_px++;
                end else begin
                    // runs mostly short, now and then long enough to pass the image end
                    run = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(61);
                    send_byte({TAG_RUN, run[5:0]}, 1'b0);
                    gen_px = gen_px + run + 1;
                end
            end
            if (mode >= 93) continue;

            // end marker, one byte wrong now and then
            bad_pos = ($urandom_range(99) < 15) ? $urandom_range(7) : 8;
            for (int k = 0; k < 8; k++) begin
                x = (k == 7) ? END_LAST_BYTE : 8'h00;
                if (k == bad_pos) begin
                    flip = rand_byte();
                    if (flip == 8'h00) flip = 8'h04;
                    x = x ^ flip;
                end
                if (k <= bad_pos) send_byte(x, 1'b0);
            end
            // trailing bytes after the end are dropped
            repeat ($urandom_range(2)) send_byte(rand_byte(), 1'b0);
        end

        // let everything drain, then give stray beats a chance to show up
        calm <= 1'b0;
        wait_for_results();
        repeat (100) @(posedge i_clk);
        if (fails == 0) begin
            $display("qoi_image_stream_decoder test passed");
        end else begin
            $display("qoi_image_stream_decoder test failed");
        end
        $finish;
    end

endmodule
